// ===== rtl/core/sorted_key_range_query_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key range query core
// Shared assertion shorthands used by the core's RTL files.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_RANGE_QUERY_CORE_MACROS_SVH
`define SORTED_KEY_RANGE_QUERY_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SKRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define SKRQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/skrq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key range query package
// Sizes, command and status codes, and the search request and response types.
// ----------------------------------------------------------------------------
package skrq_pkg;

  // Number of entries in the key table.
  localparam int unsigned DEPTH  = 4096;
  // Table address width and width of a count that can hold DEPTH itself.
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  // Fixed field widths of the word interfaces.
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned IDX_W  = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } command_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2
  } status_e;

  // Request from the controller to the search engine.
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] lower;
    logic [KEY_W-1:0] upper;
    logic [CNT_W-1:0] count;
  } search_req_t;

  // Response from the search engine: lane 0 is the lower bound position,
  // lane 1 the position just past the upper bound.
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] first_pos;
    logic [CNT_W-1:0] end_pos;
  } search_rsp_t;

endpackage

// ===== rtl/core/skrq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module skrq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/skrq_search.sv =====
// ----------------------------------------------------------------------------
// Sorted key range query search engine
// Two binary searches interleaved on one memory read port, one lane a cycle.
// ----------------------------------------------------------------------------
`include "sorted_key_range_query_core_macros.svh"

module skrq_search
  import skrq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  search_req_t       req_i,
  output search_rsp_t       rsp_o,
  output logic              rd_en_o,
  output logic [ADDR_W-1:0] rd_addr_o,
  input  logic [KEY_W-1:0]  rd_data_i
);

  // Lane 0 finds the first key at or above the lower bound, lane 1 the
  // first key above the upper bound. The lanes take turns on the read port,
  // so each lane sees its read data during the other lane's turn.
  logic             busy_q, busy_d;
  logic             phase_q, phase_d;
  logic [CNT_W-1:0] lo_q [2];
  logic [CNT_W-1:0] lo_d [2];
  logic [CNT_W-1:0] hi_q [2];
  logic [CNT_W-1:0] hi_d [2];
  logic [CNT_W-1:0] mid_q [2];
  logic [CNT_W-1:0] mid_d [2];
  logic [KEY_W-1:0] bound_q [2];
  logic [KEY_W-1:0] bound_d [2];
  logic [1:0]       pend_q, pend_d;

  logic [CNT_W-1:0] mid_c [2];
  logic             cur, oth;
  logic             before_c;
  logic             done_c;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mid_c[l] = lo_q[l] + ((hi_q[l] - lo_q[l]) >> 1);
    end
    cur = phase_q;
    oth = ~phase_q;
    done_c = busy_q && (lo_q[0] >= hi_q[0]) && (lo_q[1] >= hi_q[1]) && (pend_q == 2'b00);
    // The upper lane counts keys equal to its bound as lying before it.
    before_c = oth ? (rd_data_i <= bound_q[oth]) : (rd_data_i < bound_q[oth]);
  end

  always_comb begin
    busy_d   = busy_q;
    phase_d  = phase_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    bound_d  = bound_q;
    pend_d   = pend_q;
    rd_en_o  = 1'b0;
    rd_addr_o = mid_c[cur][ADDR_W-1:0];

    if (busy_q) begin
      phase_d = ~phase_q;
      if (pend_q[oth]) begin
        if (before_c) begin
          lo_d[oth] = mid_q[oth] + CNT_W'(1);
        end else begin
          hi_d[oth] = mid_q[oth];
        end
        pend_d[oth] = 1'b0;
      end
      if (lo_q[cur] < hi_q[cur]) begin
        rd_en_o     = 1'b1;
        mid_d[cur]  = mid_c[cur];
        pend_d[cur] = 1'b1;
      end
      if (done_c) begin
        busy_d = 1'b0;
      end
    end

    if (req_i.start) begin
      busy_d     = 1'b1;
      phase_d    = 1'b0;
      pend_d     = 2'b00;
      lo_d[0]    = '0;
      lo_d[1]    = '0;
      hi_d[0]    = req_i.count;
      hi_d[1]    = req_i.count;
      bound_d[0] = req_i.lower;
      bound_d[1] = req_i.upper;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      pend_q  <= 2'b00;
      for (int l = 0; l < 2; l++) begin
        lo_q[l]    <= '0;
        hi_q[l]    <= '0;
        mid_q[l]   <= '0;
        bound_q[l] <= '0;
      end
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      pend_q  <= pend_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      mid_q   <= mid_d;
      bound_q <= bound_d;
    end
  end

  assign rsp_o.done      = done_c;
  assign rsp_o.first_pos = lo_q[0];
  assign rsp_o.end_pos   = lo_q[1];

  `SKRQ_ASSERT(a_one_read_in_flight, !(pend_q[0] && pend_q[1]), "both lanes have reads in flight")
  `SKRQ_ASSERT_IMP(a_read_only_busy, rd_en_o, busy_q, "memory read issued while idle")
  `SKRQ_ASSERT_IMP(a_window_ordered, busy_q && !req_i.start,
    (lo_q[0] <= hi_q[0]) && (lo_q[1] <= hi_q[1]), "search window inverted")

endmodule

// ===== rtl/core/sorted_key_range_query_core.sv =====
// ----------------------------------------------------------------------------
// Sorted key range query core
// Sorted key table with append, clear and inclusive range query by binary
// search.
// ----------------------------------------------------------------------------
// The core keeps up to DEPTH unsigned Q16.16 keys in one synchronous RAM,
// appended in nondecreasing order after a clear. A query word returns the
// index of the first key at or above its lower bound and the number of keys
// inside the closed range [key, upper_key]. Clear and append words pass from
// acceptance through the pending result register into the output register.
// In a query the two binary searches share the single RAM read port,
// alternating cycles, and each probe reads a key from the RAM and then
// compares it. Appends to a full table and keys below the previous key are
// dropped with a status code. The RAM needs no clearing after reset, since
// only entries below the entry count are ever read. A new word is taken as
// soon as the previous one has moved into the output register, which it
// does only once that register is free, so a stalled output stalls input.
// ----------------------------------------------------------------------------
`include "sorted_key_range_query_core_macros.svh"

module sorted_key_range_query_core
  import skrq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] command_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [KEY_W-1:0] upper_key_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ST_W-1:0]  status_o,
  output logic [IDX_W-1:0] first_index_o,
  output logic [IDX_W-1:0] match_count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESULT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] entry_count_q, entry_count_d;
  logic [KEY_W-1:0] prev_key_q, prev_key_d;

  // Pending result, waiting for the output register.
  status_e          res_status_q, res_status_d;
  logic [CNT_W-1:0] res_first_q, res_first_d;
  logic [CNT_W-1:0] res_count_q, res_count_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [CNT_W-1:0] out_first_q, out_first_d;
  logic [CNT_W-1:0] out_count_q, out_count_d;

  logic              in_accept;
  logic              ram_we;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [KEY_W-1:0]  rd_data;
  search_req_t       search_req;
  search_rsp_t       search_rsp;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    entry_count_d = entry_count_q;
    prev_key_d    = prev_key_q;
    res_status_d  = res_status_q;
    res_first_d   = res_first_q;
    res_count_d   = res_count_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_first_d   = out_first_q;
    out_count_d   = out_count_q;
    ram_we        = 1'b0;

    search_req.start = 1'b0;
    search_req.lower = key_i;
    search_req.upper = upper_key_i;
    search_req.count = entry_count_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_status_d = ST_OK;
          res_first_d  = '0;
          res_count_d  = '0;
          state_d      = S_RESULT;
          case (command_e'(command_i))
            CMD_CLEAR: begin
              entry_count_d = '0;
              prev_key_d    = '0;
            end
            CMD_APPEND: begin
              if (entry_count_q >= CNT_W'(DEPTH)) begin
                res_status_d = ST_FULL;
              end else if ((entry_count_q != '0) && (key_i < prev_key_q)) begin
                res_status_d = ST_ORDER;
              end else begin
                ram_we        = 1'b1;
                entry_count_d = entry_count_q + CNT_W'(1);
                prev_key_d    = key_i;
              end
            end
            CMD_QUERY: begin
              search_req.start = 1'b1;
              state_d          = S_SEARCH;
            end
            default: begin
              // The unused command code leaves the table alone.
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (search_rsp.done) begin
          res_first_d = search_rsp.first_pos;
          // An inverted range leaves the end position at or below the first.
          res_count_d = (search_rsp.end_pos > search_rsp.first_pos) ?
                        (search_rsp.end_pos - search_rsp.first_pos) : '0;
          state_d     = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_first_d  = res_first_q;
          out_count_d  = res_count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      entry_count_q <= '0;
      prev_key_q    <= '0;
      res_status_q  <= ST_OK;
      res_first_q   <= '0;
      res_count_q   <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= ST_OK;
      out_first_q   <= '0;
      out_count_q   <= '0;
    end else begin
      state_q       <= state_d;
      entry_count_q <= entry_count_d;
      prev_key_q    <= prev_key_d;
      res_status_q  <= res_status_d;
      res_first_q   <= res_first_d;
      res_count_q   <= res_count_d;
      out_valid_q   <= out_valid_d;
      out_status_q  <= out_status_d;
      out_first_q   <= out_first_d;
      out_count_q   <= out_count_d;
    end
  end

  // The key table. Appends write at the current entry count, the search
  // engine reads; the two never run in the same cycle.
  skrq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_count_q[ADDR_W-1:0]),
    .wdata_i (key_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  skrq_search u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (search_req),
    .rsp_o     (search_rsp),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign first_index_o = IDX_W'(out_first_q);
  assign match_count_o = IDX_W'(out_count_q);

  `SKRQ_ASSERT(a_count_bounded, entry_count_q <= CNT_W'(DEPTH), "entry count exceeds table depth")
  `SKRQ_ASSERT_IMP(a_write_legal, ram_we,
    in_accept && (entry_count_q < CNT_W'(DEPTH)), "table write without a legal append")
  `SKRQ_ASSERT_IMP(a_done_in_search, search_rsp.done, state_q == S_SEARCH,
    "search finished outside a query")

endmodule
